@@ design/ssh_pkg.sv @@
// Types, constants and start-value helpers shared by the selectable string hash.
package ssh_pkg;

  typedef enum logic [3:0] {
    ALG_RS     = 4'd0,
    ALG_JS     = 4'd1,
    ALG_PJW    = 4'd2,
    ALG_ELF    = 4'd3,
    ALG_BKDR   = 4'd4,
    ALG_SDBM   = 4'd5,
    ALG_TIME33 = 4'd6,
    ALG_DJB    = 4'd7,
    ALG_AP     = 4'd8,
    ALG_NR     = 4'd9,
    ALG_FNV    = 4'd10,
    ALG_MUL31  = 4'd11
  } alg_t;

  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] rs_factor;
    logic [31:0] step_addend;
    logic        odd_position;
  } ssh_state_t;

  localparam logic [31:0] RS_B       = 32'd378551;
  localparam logic [31:0] RS_A0      = 32'd63689;
  localparam logic [31:0] JS_INIT    = 32'd1315423911;
  localparam logic [31:0] ELF_HIGH   = 32'hF000_0000;
  localparam logic [31:0] BKDR_SEED  = 32'd131;
  localparam logic [31:0] DJB_INIT   = 32'd5381;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam logic [31:0] NR_INIT    = 32'd1;
  localparam logic [31:0] NR_ADDEND0 = 32'd4;
  localparam logic [31:0] NR_STEP    = 32'd3;
  localparam logic [31:0] MUL31      = 32'd31;

  function automatic alg_t clamp_alg(input logic [3:0] v);
    alg_t a;
    if (v > 4'(ALG_MUL31)) begin
      a = ALG_MUL31;
    end else begin
      a = alg_t'(v);
    end
    return a;
  endfunction

  function automatic ssh_state_t start_state(input alg_t a);
    ssh_state_t s;
    s.rs_factor    = RS_A0;
    s.step_addend  = NR_ADDEND0;
    s.odd_position = 1'b0;
    case (a)
      ALG_JS:  s.hash = JS_INIT;
      ALG_DJB: s.hash = DJB_INIT;
      ALG_NR:  s.hash = NR_INIT;
      default: s.hash = 32'd0;
    endcase
    return s;
  endfunction

endpackage

@@ design/ssh_step.sv @@
// One-byte update of the running hash state for the selected algorithm.
module ssh_step (
  input  ssh_pkg::alg_t       alg,
  input  ssh_pkg::ssh_state_t cur,
  input  logic [7:0]          data_byte,
  output ssh_pkg::ssh_state_t nxt
);
  import ssh_pkg::*;

  logic [31:0] c32;
  logic [31:0] h;
  logic [31:0] rs_mul;
  logic [31:0] rs_fac_mul;
  logic [31:0] fnv_mul;
  logic [31:0] nr_mul;
  logic [31:0] bkdr_mul;
  logic [31:0] elf_sum;
  logic [31:0] elf_x;

  assign c32        = {24'd0, data_byte};
  assign h          = cur.hash;
  assign rs_mul     = h * cur.rs_factor;
  assign rs_fac_mul = cur.rs_factor * RS_B;
  assign fnv_mul    = h * FNV_PRIME;
  assign bkdr_mul   = h * BKDR_SEED;
  assign nr_mul     = ({26'd0, h[5:0]} + cur.step_addend) * c32;
  assign elf_sum    = (h << 4) + c32;
  assign elf_x      = elf_sum & ELF_HIGH;

  always_comb begin
    nxt = cur;
    case (alg)
      ALG_RS: begin
        nxt.hash      = rs_mul + c32;
        nxt.rs_factor = rs_fac_mul;
      end
      ALG_JS:               nxt.hash = h ^ ((h << 5) + c32 + (h >> 2));
      ALG_PJW, ALG_ELF:     nxt.hash = (elf_sum ^ (elf_x >> 24)) & ~elf_x;
      ALG_BKDR:             nxt.hash = bkdr_mul + c32;
      ALG_SDBM:             nxt.hash = c32 + (h << 6) + (h << 16) - h;
      ALG_TIME33, ALG_DJB:  nxt.hash = (h << 5) + h + c32;
      ALG_AP: begin
        if (!cur.odd_position) begin
          nxt.hash = h ^ ((h << 7) ^ c32 ^ (h >> 3));
        end else begin
          nxt.hash = h ^ ~((h << 11) ^ c32 ^ (h >> 5));
        end
        nxt.odd_position = ~cur.odd_position;
      end
      ALG_NR: begin
        nxt.hash        = h ^ (nr_mul + (h << 8));
        nxt.step_addend = cur.step_addend + NR_STEP;
      end
      ALG_FNV:              nxt.hash = fnv_mul ^ c32;
      default:              nxt.hash = (h * MUL31) + c32;
    endcase
  end

endmodule

@@ design/selectable_string_hash.sv @@
// Top level of the selectable byte-stream string hash.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | data_byte, has_byte, last_byte
//  out_    | output    | out_valid/out_stall| hash_value
//  cfg_    | input     | cfg_valid/cfg_ready| algorithm
//
// One byte per cycle, except while a last item waits on a stalled result.
// The byte goes through an input register, then the combinational state update
// writes the hash state and, on a last item, the result register.
// The hash state recurrence is combinational, so items follow back to back.
// A last item waits in the input register only while an earlier result is stalled.
// Reset (rst_n, synchronous) selects RS and loads its start values.
module selectable_string_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_algorithm
);
  import ssh_pkg::*;

  alg_t       alg_r, alg_nxt;
  ssh_state_t st_r, st_nxt;
  ssh_state_t step_out;
  ssh_state_t absorbed;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_has_r;
  logic       s1_last_r;
  logic       out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;

  logic in_xfer;
  logic cfg_xfer;
  logic s1_adv;

  ssh_step u_step (
    .alg       (alg_r),
    .cur       (st_r),
    .data_byte (s1_byte_r),
    .nxt       (step_out)
  );

  assign s1_adv    = s1_valid_r && !(s1_last_r && out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = !s1_valid_r;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign absorbed  = s1_has_r ? step_out : st_r;

  always_comb begin
    alg_nxt       = alg_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hash_nxt  = out_hash_r;
    s1_valid_nxt  = in_xfer || (s1_valid_r && !s1_adv);
    if (cfg_xfer) begin
      alg_nxt = clamp_alg(cfg_algorithm);
      st_nxt  = start_state(clamp_alg(cfg_algorithm));
    end else if (s1_adv) begin
      if (s1_last_r) begin
        st_nxt        = start_state(alg_r);
        out_valid_nxt = 1'b1;
        out_hash_nxt  = absorbed.hash;
      end else begin
        st_nxt = absorbed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alg_r       <= ALG_RS;
      st_r        <= start_state(ALG_RS);
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      alg_r       <= alg_nxt;
      st_r        <= st_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_data_byte;
      s1_has_r  <= in_has_byte;
      s1_last_r <= in_last_byte;
    end
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

@@ design/ssh_chk.sv @@
// Port-level checker for the selectable string hash, bound to the top level.
module ssh_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_hash_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_hash_value)))
    else $error("stalled result dropped or changed");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_byte) |-> ##2 out_valid)
    else $error("last item transfer produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_last_byte, 2))
    else $error("result without a last item transfer");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side free");

endmodule

bind selectable_string_hash ssh_chk u_ssh_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_last_byte   (in_last_byte),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hash_value (out_hash_value)
);
